[rtl/qspt_pkg.sv]
// shared types, constants and register codes of the quadrature speed and position tracker
package qspt_pkg;

    localparam int DATA_W    = 32;
    localparam int ANGLE_W   = 48;
    localparam int ALPHA_W   = 17;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // digit-serial multiplier geometry
    localparam int DIGIT_W   = 4;
    localparam int MUL_DIGITS = DATA_W / DIGIT_W;
    localparam int CNT_W     = $clog2(MUL_DIGITS);
    localparam int MCAND_W   = DATA_W + 2;
    localparam int HI_W      = MCAND_W + DIGIT_W + 1;
    localparam int PROD_W    = HI_W + DATA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    localparam logic [DATA_W-1:0]  RPM_SCALE_RST = DATA_W'(983040);
    localparam logic [DATA_W-1:0]  DEG_SCALE_RST = DATA_W'(5898240);

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_RPM_SCALE = 2'd1,
        REG_DEG_SCALE = 2'd2,
        REG_ALPHA     = 2'd3
    } reg_idx_t;

    typedef enum logic {
        FUNC_UPDATE = 1'b0,
        FUNC_ZERO   = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RPM,
        ST_RPM_WAIT,
        ST_FILT,
        ST_FILT_WAIT,
        ST_ANG,
        ST_ANG_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 counter_is_16bit;
        logic [DATA_W-1:0]    rpm_scale;
        logic [DATA_W-1:0]    deg_scale;
        logic [ALPHA_W-1:0]   filter_alpha;
    } cfg_t;

    typedef struct packed {
        logic                 func;
        logic [DATA_W-1:0]    counter_value;
        logic                 counting_down;
    } sample_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  step_delta;
        logic signed [DATA_W-1:0]  total_count;
        logic signed [DATA_W-1:0]  rpm_unfiltered;
        logic signed [DATA_W-1:0]  rpm_smoothed;
        logic signed [ANGLE_W-1:0] angle_degrees;
        logic                      direction;
    } result_t;

    typedef struct packed {
        logic                       start;
        logic signed [MCAND_W-1:0]  mcand;
        logic [DATA_W-1:0]          mult;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [PROD_W-1:0]   product;
    } mul_rsp_t;

endpackage

[rtl/qspt_regs.sv]
// apb configuration registers
module qspt_regs
    import qspt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_MODE:      cfg_next.counter_is_16bit = pwdata[0];
                REG_RPM_SCALE: cfg_next.rpm_scale        = pwdata;
                REG_DEG_SCALE: cfg_next.deg_scale        = pwdata;
                REG_ALPHA:     cfg_next.filter_alpha     = pwdata[ALPHA_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_MODE:      prdata = PDATA_W'(cfg_reg.counter_is_16bit);
            REG_RPM_SCALE: prdata = cfg_reg.rpm_scale;
            REG_DEG_SCALE: prdata = cfg_reg.deg_scale;
            REG_ALPHA:     prdata = PDATA_W'(cfg_reg.filter_alpha);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counter_is_16bit <= 1'b0;
            cfg_reg.rpm_scale        <= RPM_SCALE_RST;
            cfg_reg.deg_scale        <= DEG_SCALE_RST;
            cfg_reg.filter_alpha     <= ALPHA_ONE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[rtl/qspt_mul.sv]
// digit-serial signed by unsigned multiplier, one 4-bit digit of the multiplier per cycle
module qspt_mul
    import qspt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic signed [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [DATA_W-1:0]         mult_reg, mult_next;
    logic signed [HI_W-1:0]    hi_reg, hi_next;
    logic [DATA_W-1:0]         lo_reg, lo_next;
    logic signed [HI_W-1:0]    pp;
    logic signed [HI_W-1:0]    sum;

    // partial product of the multiplicand and the current low digit
    assign pp  = HI_W'(mcand_reg) * HI_W'($signed({1'b0, mult_reg[DIGIT_W-1:0]}));
    assign sum = hi_reg + pp;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        mult_next  = mult_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            mcand_next = req.mcand;
            mult_next  = req.mult;
            hi_next    = '0;
            lo_next    = '0;
        end
        else if (busy_reg)
        begin
            hi_next   = sum >>> DIGIT_W;
            lo_next   = {sum[DIGIT_W-1:0], lo_reg[DATA_W-1:DIGIT_W]};
            mult_next = mult_reg >> DIGIT_W;
            cnt_next  = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(MUL_DIGITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        mult_reg  <= mult_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
    end

    assign rsp.done    = done_reg;
    assign rsp.product = {hi_reg, lo_reg};

endmodule

[rtl/quadrature_speed_position_tracker.sv]
// top level: sample intake, sequencer, tracking state and result register
//
// Usage: each transaction on the sample channel (sample_valid/sample_ready)
// carries one reading of a quadrature counter with a function code and the
// counting direction. Every sample transaction yields exactly one transaction
// on the result channel (result_valid/result_ready) with delta, accumulated
// count, raw and filtered rpm, angle and direction.
// Configuration goes through the APB port; pready is always high.
// Processing: an update sample runs the rpm, filter and angle products in
// turn on the single shared multiplier, a zero command only the angle
// product. The multiplier consumes one 4-bit digit per cycle and runs
// eight digits for each product.
// One sample is worked on at a time. A new sample may be taken while the
// previous result still waits in the result register; if the receiver
// stalls, the finished result of that next sample waits in the sequencer
// until the result register frees up, and no further sample is taken.
// Reset clears the tracking state (all but the angle register), drops any
// pending result and restores the configuration defaults.
module quadrature_speed_position_tracker
    import qspt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    input  logic               sample_valid,
    output logic               sample_ready,
    input  sample_t            sample,
    output logic               result_valid,
    input  logic               result_ready,
    output result_t            result
);

    cfg_t     cfg;
    mul_req_t mreq;
    mul_rsp_t mrsp;

    state_t state_reg, state_next;

    logic [DATA_W-1:0]          prev_reg, prev_next;
    logic [DATA_W-1:0]          count_reg, count_next;
    logic signed [DATA_W-1:0]   filt_reg, filt_next;
    logic signed [DATA_W-1:0]   delta_reg, delta_next;
    logic signed [DATA_W-1:0]   raw_reg, raw_next;
    logic                       dir_reg, dir_next;
    logic signed [ANGLE_W-1:0]  angle_reg, angle_next;
    logic                       out_valid_reg, out_valid_next;
    result_t                    out_reg, out_next;

    logic                       accept;
    logic                       load_out;
    logic [15:0]                d16;
    logic [DATA_W-1:0]          delta_w;
    logic [ALPHA_W-1:0]         alpha_sat;
    logic signed [MCAND_W-1:0]  diff;
    logic signed [PROD_W-DATA_W/2-1:0] filt_step;
    logic                       raw_fits;
    logic                       ang_fits;

    qspt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    qspt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign sample_ready = (state_reg == ST_IDLE);
    assign accept       = sample_valid & sample_ready;
    assign load_out     = (state_reg == ST_DONE) && (!out_valid_reg || result_ready);

    // delta folded to the active counter width
    assign d16     = sample.counter_value[15:0] - prev_reg[15:0];
    assign delta_w = cfg.counter_is_16bit ? {{16{d16[15]}}, d16}
                                          : sample.counter_value - prev_reg;

    assign alpha_sat = (cfg.filter_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.filter_alpha;
    assign diff      = MCAND_W'(raw_reg) - MCAND_W'(filt_reg);
    assign filt_step = mrsp.product[PROD_W-1:DATA_W/2];

    assign raw_fits = (mrsp.product[PROD_W-1:DATA_W-1]
                       == {(PROD_W-DATA_W+1){mrsp.product[PROD_W-1]}});
    assign ang_fits = (mrsp.product[PROD_W-1:ANGLE_W-1]
                       == {(PROD_W-ANGLE_W+1){mrsp.product[PROD_W-1]}});

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = (sample.func == FUNC_ZERO) ? ST_ANG : ST_RPM;
            end
            ST_RPM:       state_next = ST_RPM_WAIT;
            ST_RPM_WAIT:  if (mrsp.done) state_next = ST_FILT;
            ST_FILT:      state_next = ST_FILT_WAIT;
            ST_FILT_WAIT: if (mrsp.done) state_next = ST_ANG;
            ST_ANG:       state_next = ST_ANG_WAIT;
            ST_ANG_WAIT:  if (mrsp.done) state_next = ST_DONE;
            ST_DONE:      if (load_out) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // multiplier operand selection
    always_comb
    begin
        mreq.start = 1'b0;
        mreq.mcand = MCAND_W'(delta_reg);
        mreq.mult  = cfg.rpm_scale;
        case (state_reg)
            ST_RPM:
            begin
                mreq.start = 1'b1;
            end
            ST_FILT:
            begin
                mreq.start = 1'b1;
                mreq.mcand = diff;
                mreq.mult  = DATA_W'(alpha_sat);
            end
            ST_ANG:
            begin
                mreq.start = 1'b1;
                mreq.mcand = MCAND_W'($signed(count_reg));
                mreq.mult  = cfg.deg_scale;
            end
            default:
            begin
                mreq.start = 1'b0;
            end
        endcase
    end

    // tracking state and result register updates
    always_comb
    begin
        prev_next      = prev_reg;
        count_next     = count_reg;
        filt_next      = filt_reg;
        delta_next     = delta_reg;
        raw_next       = raw_reg;
        dir_next       = dir_reg;
        angle_next     = angle_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sample.func == FUNC_ZERO)
                    begin
                        count_next = '0;
                    end
                    else
                    begin
                        prev_next  = cfg.counter_is_16bit
                                     ? {16'b0, sample.counter_value[15:0]}
                                     : sample.counter_value;
                        delta_next = $signed(delta_w);
                        count_next = count_reg + delta_w;
                        dir_next   = sample.counting_down;
                    end
                end
            end
            ST_RPM_WAIT:
            begin
                if (mrsp.done)
                begin
                    if (raw_fits)
                        raw_next = mrsp.product[DATA_W-1:0];
                    else
                        raw_next = mrsp.product[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}}
                                                          : {1'b0, {(DATA_W-1){1'b1}}};
                end
            end
            ST_FILT_WAIT:
            begin
                if (mrsp.done)
                    filt_next = filt_reg + filt_step[DATA_W-1:0];
            end
            ST_ANG_WAIT:
            begin
                if (mrsp.done)
                begin
                    if (ang_fits)
                        angle_next = mrsp.product[ANGLE_W-1:0];
                    else
                        angle_next = mrsp.product[PROD_W-1] ? {1'b1, {(ANGLE_W-1){1'b0}}}
                                                            : {1'b0, {(ANGLE_W-1){1'b1}}};
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next          = 1'b1;
                    out_next.step_delta     = delta_reg;
                    out_next.total_count    = $signed(count_reg);
                    out_next.rpm_unfiltered = raw_reg;
                    out_next.rpm_smoothed   = filt_reg;
                    out_next.angle_degrees  = angle_reg;
                    out_next.direction      = dir_reg;
                end
            end
            default:
            begin
                out_next = out_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            count_reg     <= '0;
            filt_reg      <= '0;
            delta_reg     <= '0;
            raw_reg       <= '0;
            dir_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            filt_reg      <= filt_next;
            delta_reg     <= delta_next;
            raw_reg       <= raw_next;
            dir_reg       <= dir_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        angle_reg <= angle_next;
        out_reg   <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
